// File: sv/priority_ready_queue_macros.svh
// Assertion macros used by the checker file of the priority ready queue.
`ifndef PRIORITY_READY_QUEUE_MACROS_SVH
`define PRIORITY_READY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("priority ready queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("priority ready queue check failed");

`endif

// File: sv/prq_pkg.sv
// Shared types and constants of the priority ready queue.
`default_nettype none

package prq_pkg;

  // Fixed field widths of the input and result beats.
  localparam int IdW   = 6;
  localparam int PrioW = 5;

  // Operation carried by an input beat.
  typedef enum logic [0:0] {
    ActAppend = 1'b0,
    ActTake   = 1'b1
  } action_e;

endpackage

`default_nettype wire

// File: sv/prq_if.sv
// Valid/ready channel interfaces for the input and result beats.
`default_nettype none

interface prq_in_if;
  logic                          valid;
  logic                          ready;
  prq_pkg::action_e              action;
  logic [prq_pkg::IdW-1:0]       task_id;
  logic [prq_pkg::PrioW-1:0]     priority_req;

  modport source (output valid, action, task_id, priority_req, input ready);
  modport sink   (input valid, action, task_id, priority_req, output ready);
endinterface

interface prq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [prq_pkg::IdW-1:0]       ready_task;

  modport source (output valid, found, ready_task, input ready);
  modport sink   (input valid, found, ready_task, output ready);
endinterface

`default_nettype wire

// File: sv/prq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module prq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write first in program order, but a read in the same cycle returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/priority_ready_queue.sv
// Priority ready queue: per-level FIFOs of task slots linked through a next-link RAM.
//
// The block holds LEVELS priority levels, each a FIFO of task slots kept as a linked
// list with a head and a tail per level and a mask bit per non-empty level. An append
// beat links a task at the tail of its level and returns nothing; a take beat removes
// the head of the lowest-numbered non-empty level and returns it, or returns found = 0
// with task 0 when every level is empty. The state is updated in a single pass and a
// take's result is in the output register in the cycle after acceptance, so one beat
// per cycle is sustained while the result side keeps taking results. What makes the
// single pass possible is the next-link RAM, whose registered read port is aimed every
// cycle at the head of the level that the next take will use, with a one-entry bypass
// for a link written in that same cycle. No clearing pass is needed after reset: a
// flip-flop per slot marks whether its link is live.
`default_nettype none

module priority_ready_queue #(
  parameter int LEVELS     = 32,
  parameter int TASK_SLOTS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  prq_in_if.sink      in_i,
  prq_out_if.source   out_o
);

  localparam int LevelW = $clog2(LEVELS);
  localparam int SlotW  = $clog2(TASK_SLOTS);

  // Index of the lowest set bit; returns 0 when the mask is zero.
  function automatic logic [LevelW-1:0] lowest_level(input logic [LEVELS-1:0] m);
    logic [LEVELS-1:0] one_hot;
    logic [LevelW-1:0] idx;
    one_hot = m & (~m + LEVELS'(1));
    idx     = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (one_hot[i]) begin
        idx |= LevelW'(i);
      end
    end
    return idx;
  endfunction

  // Queue state.
  logic [LEVELS-1:0]     mask_q, mask_d;
  logic [SlotW-1:0]      head_q [LEVELS];
  logic [SlotW-1:0]      head_d [LEVELS];
  logic [SlotW-1:0]      tail_q [LEVELS];
  logic [SlotW-1:0]      tail_d [LEVELS];
  logic [TASK_SLOTS-1:0] link_vld_q, link_vld_d;

  // Next-link RAM ports and read bypass.
  logic                  ram_we;
  logic [SlotW-1:0]      ram_waddr;
  logic [SlotW-1:0]      ram_wdata;
  logic [SlotW-1:0]      ram_raddr;
  logic [SlotW-1:0]      ram_rdata;
  logic                  byp_q;
  logic [SlotW-1:0]      byp_data_q;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  logic                  found_q, found_d;
  logic [prq_pkg::IdW-1:0] task_q, task_d;

  // Decoded input beat.
  logic                  in_fire;
  logic                  append_ok;
  logic [SlotW-1:0]      a_slot;
  logic [LevelW-1:0]     a_lvl;
  logic [LevelW-1:0]     take_lvl;
  logic [SlotW-1:0]      take_head;
  logic [SlotW-1:0]      nx_slot;
  logic                  nx_vld;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  assign a_slot    = SlotW'(in_i.task_id);
  assign a_lvl     = LevelW'(in_i.priority_req);
  assign append_ok = (32'(in_i.task_id) < TASK_SLOTS) && (32'(in_i.priority_req) < LEVELS);

  // Head of the most urgent level and its successor, read ahead from the link RAM or its bypass.
  assign take_lvl  = lowest_level(mask_q);
  assign take_head = head_q[take_lvl];
  assign nx_slot   = byp_q ? byp_data_q : ram_rdata;
  assign nx_vld    = link_vld_q[take_head];

  // Single-pass state update for one accepted beat.
  always_comb begin
    mask_d      = mask_q;
    head_d      = head_q;
    tail_d      = tail_q;
    link_vld_d  = link_vld_q;
    ram_we      = 1'b0;
    ram_waddr   = tail_q[a_lvl];
    ram_wdata   = a_slot;
    found_d     = found_q;
    task_d      = task_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (in_fire) begin
      unique case (in_i.action)
        prq_pkg::ActAppend: begin
          if (append_ok) begin
            link_vld_d[a_slot] = 1'b0;
            if (mask_q[a_lvl]) begin
              ram_we                     = 1'b1;
              link_vld_d[tail_q[a_lvl]] = 1'b1;
            end else begin
              head_d[a_lvl] = a_slot;
            end
            mask_d[a_lvl] = 1'b1;
            tail_d[a_lvl] = a_slot;
          end
        end
        prq_pkg::ActTake: begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          task_d      = '0;
          if (mask_q != '0) begin
            found_d               = 1'b1;
            task_d                = prq_pkg::IdW'(take_head);
            link_vld_d[take_head] = 1'b0;
            if (nx_vld) begin
              head_d[take_lvl] = nx_slot;
            end else begin
              mask_d[take_lvl] = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Aim the link read at the head that the next take will remove.
  assign ram_raddr = head_d[lowest_level(mask_d)];

  prq_ram #(
    .WIDTH (SlotW),
    .DEPTH (TASK_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      link_vld_q  <= '0;
      out_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      link_vld_q  <= link_vld_d;
      out_valid_q <= out_valid_d;
      byp_q       <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  // Payload state.
  always_ff @(posedge clk_i) begin
    head_q     <= head_d;
    tail_q     <= tail_d;
    byp_data_q <= ram_wdata;
    found_q    <= found_d;
    task_q     <= task_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.found      = found_q;
  assign out_o.ready_task = task_q;

endmodule

`default_nettype wire

// File: sv/prq_checker.sv
// Port-level checks of the priority ready queue and their binding to the top level.
`default_nettype none
`include "priority_ready_queue_macros.svh"

module prq_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_ready_i,
  input wire [0:0]                in_action_i,
  input wire                      out_valid_i,
  input wire                      out_ready_i,
  input wire                      out_found_i,
  input wire [prq_pkg::IdW-1:0]   out_ready_task_i
);

  logic in_fire;
  logic is_take;

  assign in_fire = in_valid_i && in_ready_i;
  assign is_take = (in_action_i == prq_pkg::ActTake);

  // An empty take reports task zero.
  `PRQ_ASSERT_IMP(a_empty_task_zero, clk_i, rst_ni, out_valid_i && !out_found_i, out_ready_task_i == '0)

  // Every accepted take shows a result in the following cycle.
  `PRQ_ASSERT_NXT(a_take_gives_result, clk_i, rst_ni, in_fire && is_take, out_valid_i)

  // An append never creates a result on an idle result channel.
  `PRQ_ASSERT_NXT(a_append_no_result, clk_i, rst_ni, in_fire && !is_take && !out_valid_i, !out_valid_i)

  // A stalled result beat holds.
  `PRQ_ASSERT_NXT(a_result_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_found_i) && $stable(out_ready_task_i))

endmodule

bind priority_ready_queue prq_checker u_prq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_action_i      (in_i.action),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_found_i      (out_o.found),
  .out_ready_task_i (out_o.ready_task)
);

`default_nettype wire
